FILE: rtl/hssc_pkg.sv
// Package with the types, codes and lookup tables of the hall sensor six-step commutator.
`default_nettype none
package hssc_pkg;

	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 16;
	localparam int unsigned StepW = 3;
	localparam int unsigned CountW = 16;
	localparam int unsigned StepCountW = 11;
	localparam int unsigned DriveW = 2;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_STARTUP_STEP_US = 3'd0,
		CFG_STARTUP_CYCLES  = 3'd1,
		CFG_SETTLE_US       = 3'd2,
		CFG_DWELL_US        = 3'd3,
		CFG_STARTUP_DRIVE   = 3'd4
	} cfg_index_t;

	typedef enum logic [1:0] {
		PH_STARTUP = 2'd0,
		PH_AWAIT   = 2'd1,
		PH_SETTLE  = 2'd2,
		PH_DWELL   = 2'd3
	} phase_t;

	typedef enum logic [DriveW-1:0] {
		DRV_FLOAT = 2'd0,
		DRV_LOW   = 2'd1,
		DRV_HIGH  = 2'd2
	} drive_t;

	typedef struct packed {
		drive_t a;
		drive_t b;
		drive_t c;
	} drive_set_t;

	localparam logic [StepW-1:0] LastStep = 3'd5;

	function automatic logic [StepW-1:0] next_step(input logic [StepW-1:0] s);
		next_step = (s >= LastStep) ? '0 : s + 3'd1;
	endfunction

	// Hall pattern {A, B, C} seen while the rotor sits in a given step.
	function automatic logic [2:0] hall_pattern(input logic [StepW-1:0] s);
		case (s)
			3'd0: hall_pattern = 3'b100;
			3'd1: hall_pattern = 3'b101;
			3'd2: hall_pattern = 3'b001;
			3'd3: hall_pattern = 3'b011;
			3'd4: hall_pattern = 3'b010;
			3'd5: hall_pattern = 3'b110;
			default: hall_pattern = 3'b100;
		endcase
	endfunction

	function automatic drive_set_t drive_of(input logic [StepW-1:0] s);
		case (s)
			3'd0: drive_of = '{a: DRV_HIGH, b: DRV_LOW, c: DRV_FLOAT};
			3'd1: drive_of = '{a: DRV_FLOAT, b: DRV_LOW, c: DRV_HIGH};
			3'd2: drive_of = '{a: DRV_LOW, b: DRV_FLOAT, c: DRV_HIGH};
			3'd3: drive_of = '{a: DRV_LOW, b: DRV_HIGH, c: DRV_FLOAT};
			3'd4: drive_of = '{a: DRV_FLOAT, b: DRV_HIGH, c: DRV_LOW};
			3'd5: drive_of = '{a: DRV_HIGH, b: DRV_FLOAT, c: DRV_LOW};
			default: drive_of = '{a: DRV_HIGH, b: DRV_LOW, c: DRV_FLOAT};
		endcase
	endfunction

endpackage
`default_nettype wire

FILE: rtl/hall_sensor_six_step_commutator.sv
// Top level of the hall sensor six-step commutator for a three-phase brushless motor.
// An accepted input item is held in the input register, and its result in the result register.
// Throughput: one item per cycle unless the output stalls; both registers decouple
// the channels, and the state update is a single pass of logic between them.
// Reset: arst_n clears the state asynchronously to open-loop startup at step zero with
// coils floating, and loads the default register values.
`default_nettype none
module hall_sensor_six_step_commutator (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_we,
	input  wire  [hssc_pkg::CfgIdxW-1:0]        cfg_index,
	input  wire  [hssc_pkg::CfgDataW-1:0]       cfg_data,
	input  wire                                 in_valid,
	output logic                                in_ready,
	input  wire                                 hall_a,
	input  wire                                 hall_b,
	input  wire                                 hall_c,
	output logic                                out_valid,
	input  wire                                 out_ready,
	output logic [hssc_pkg::DriveW-1:0]         drive_a,
	output logic [hssc_pkg::DriveW-1:0]         drive_b,
	output logic [hssc_pkg::DriveW-1:0]         drive_c,
	output logic [hssc_pkg::StepW-1:0]          current_step,
	output logic [1:0]                          current_phase
);
	import hssc_pkg::*;

	logic [CountW-1:0]     startup_step_us_q;
	logic [7:0]            startup_cycles_q;
	logic [CountW-1:0]     settle_us_q;
	logic [CountW-1:0]     dwell_us_q;
	logic                  startup_drive_q;

	logic [StepW-1:0]      step_index_q, step_index_d;
	logic [StepW-1:0]      applied_step_q, applied_step_d;
	logic                  drive_enabled_q, drive_enabled_d;
	phase_t                phase_q, phase_d;
	logic [CountW-1:0]     tick_counter_q, tick_counter_d;
	logic [StepCountW-1:0] startup_count_q, startup_count_d;

	logic                  valid_s1;
	logic [2:0]            hall_s1;
	logic                  advance;

	logic [CountW:0]       tick_inc;
	logic [CountW-1:0]     step_len;
	logic [StepCountW-1:0] startup_target;
	drive_set_t            drive_sel;

	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			startup_step_us_q <= 16'd7000;
			startup_cycles_q  <= 8'd35;
			settle_us_q       <= 16'd50;
			dwell_us_q        <= 16'd7000;
			startup_drive_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_STARTUP_STEP_US: startup_step_us_q <= cfg_data;
				CFG_STARTUP_CYCLES:  startup_cycles_q <= cfg_data[7:0];
				CFG_SETTLE_US:       settle_us_q <= cfg_data;
				CFG_DWELL_US:        dwell_us_q <= cfg_data;
				CFG_STARTUP_DRIVE:   startup_drive_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			hall_s1 <= {hall_a, hall_b, hall_c};
		end
	end

	assign tick_inc = {1'b0, tick_counter_q} + 17'd1;
	assign step_len = (startup_step_us_q == '0) ? 16'd1 : startup_step_us_q;
	assign startup_target = ({3'b0, startup_cycles_q} << 2) + ({3'b0, startup_cycles_q} << 1);

	always_comb begin
		step_index_d    = (step_index_q > LastStep) ? '0 : step_index_q;
		applied_step_d  = applied_step_q;
		drive_enabled_d = drive_enabled_q;
		phase_d         = phase_q;
		tick_counter_d  = tick_counter_q;
		startup_count_d = startup_count_q;

		unique case (phase_q)
			PH_STARTUP: begin
				if (startup_count_q >= startup_target) begin
					applied_step_d  = step_index_d;
					drive_enabled_d = 1'b1;
					phase_d         = PH_AWAIT;
					tick_counter_d  = '0;
				end else begin
					if (tick_counter_q == '0) begin
						applied_step_d  = step_index_d;
						drive_enabled_d = startup_drive_q;
					end
					tick_counter_d = tick_inc[CountW-1:0];
					if (tick_inc >= {1'b0, step_len}) begin
						tick_counter_d  = '0;
						step_index_d    = next_step(step_index_d);
						startup_count_d = startup_count_q + 11'd1;
						if (startup_count_d >= startup_target) begin
							applied_step_d  = step_index_d;
							drive_enabled_d = 1'b1;
							phase_d         = PH_AWAIT;
						end
					end
				end
			end
			PH_SETTLE: begin
				tick_counter_d = tick_inc[CountW-1:0];
				if (tick_inc >= {1'b0, settle_us_q}) begin
					step_index_d   = next_step(step_index_d);
					tick_counter_d = '0;
					phase_d        = PH_DWELL;
					if (dwell_us_q == '0) begin
						applied_step_d  = step_index_d;
						drive_enabled_d = 1'b1;
						phase_d         = PH_AWAIT;
					end
				end
			end
			PH_DWELL: begin
				tick_counter_d = tick_inc[CountW-1:0];
				if (tick_inc >= {1'b0, dwell_us_q}) begin
					applied_step_d  = step_index_d;
					drive_enabled_d = 1'b1;
					phase_d         = PH_AWAIT;
					tick_counter_d  = '0;
				end
			end
			PH_AWAIT: ;
			default: ;
		endcase

		// The hall check also runs on the tick that enters the await phase.
		if (phase_d == PH_AWAIT && hall_s1 == hall_pattern(next_step(step_index_d))) begin
			tick_counter_d = '0;
			phase_d        = PH_SETTLE;
			if (settle_us_q == '0) begin
				step_index_d = next_step(step_index_d);
				phase_d      = PH_DWELL;
				if (dwell_us_q == '0) begin
					applied_step_d  = step_index_d;
					drive_enabled_d = 1'b1;
					phase_d         = PH_AWAIT;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_index_q    <= '0;
			applied_step_q  <= '0;
			drive_enabled_q <= 1'b0;
			phase_q         <= PH_STARTUP;
			tick_counter_q  <= '0;
			startup_count_q <= '0;
		end else if (advance) begin
			step_index_q    <= step_index_d;
			applied_step_q  <= applied_step_d;
			drive_enabled_q <= drive_enabled_d;
			phase_q         <= phase_d;
			tick_counter_q  <= tick_counter_d;
			startup_count_q <= startup_count_d;
		end
	end

	assign drive_sel = drive_of((applied_step_d > LastStep) ? '0 : applied_step_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			drive_a       <= drive_enabled_d ? drive_sel.a : DRV_FLOAT;
			drive_b       <= drive_enabled_d ? drive_sel.b : DRV_FLOAT;
			drive_c       <= drive_enabled_d ? drive_sel.c : DRV_FLOAT;
			current_step  <= step_index_d;
			current_phase <= phase_d;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/hssc_checker.sv
// Port-level checker for the hall sensor six-step commutator and its bind statement.
`default_nettype none
module hssc_checker (
	input wire                            clk,
	input wire                            arst_n,
	input wire                            out_valid,
	input wire                            out_ready,
	input wire [hssc_pkg::DriveW-1:0]     drive_a,
	input wire [hssc_pkg::DriveW-1:0]     drive_b,
	input wire [hssc_pkg::StepW-1:0]      current_step,
	input wire [1:0]                      current_phase
);
	import hssc_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result item dropped while stalled");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> current_step <= LastStep)
		else $error("step index out of range");

	a_closed_loop_drives: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && current_phase != PH_STARTUP |-> drive_a != DRV_FLOAT || drive_b != DRV_FLOAT)
		else $error("coils floating in closed loop");

	a_no_return_to_startup: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && current_phase != PH_STARTUP
		|=> !out_valid || current_phase != PH_STARTUP)
		else $error("phase went back to startup");

endmodule

bind hall_sensor_six_step_commutator hssc_checker u_hssc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.drive_a       (drive_a),
	.drive_b       (drive_b),
	.current_step  (current_step),
	.current_phase (current_phase)
);
`default_nettype wire

FILE: tb/hssc_tb_pkg.sv
// Scoreboard class that predicts and checks the drive items of the six-step commutator.
`timescale 1ns / 100ps
package hssc_tb_pkg;
	import hssc_pkg::*;

	typedef struct packed {
		drive_t a;
		drive_t b;
		drive_t c;
		logic [StepW-1:0] step;
		phase_t phase;
	} drive_item_t;

	function automatic logic [StepW-1:0] after_step(input logic [StepW-1:0] s);
		return (s >= LastStep) ? '0 : s + 1'b1;
	endfunction

	function automatic logic [2:0] hall_code(input logic [StepW-1:0] s);
		case (s)
			3'd0: return 3'b100;
			3'd1: return 3'b101;
			3'd2: return 3'b001;
			3'd3: return 3'b011;
			3'd4: return 3'b010;
			default: return 3'b110;
		endcase
	endfunction

	class commutation_scoreboard;
		int unsigned boot_len;
		int unsigned boot_cycles;
		int unsigned settle_len;
		int unsigned dwell_len;
		bit boot_drive;
		logic [StepW-1:0] step_idx;
		logic [StepW-1:0] applied;
		bit drive_on;
		phase_t ph;
		int unsigned ticks;
		logic [StepCountW-1:0] boot_steps;
		drive_item_t pending_drives[$];
		int unsigned failures;

		function new();
			boot_len = 7000;
			boot_cycles = 35;
			settle_len = 50;
			dwell_len = 7000;
			boot_drive = 1'b0;
			step_idx = '0;
			applied = '0;
			drive_on = 1'b0;
			ph = PH_STARTUP;
			ticks = 0;
			boot_steps = '0;
			failures = 0;
		endfunction

		function void write_reg(cfg_index_t idx, logic [CfgDataW-1:0] value);
			case (idx)
				CFG_STARTUP_STEP_US: boot_len = value;
				CFG_STARTUP_CYCLES: boot_cycles = value[7:0];
				CFG_SETTLE_US: settle_len = value;
				CFG_DWELL_US: dwell_len = value;
				CFG_STARTUP_DRIVE: boot_drive = value[0];
				default: ;
			endcase
		endfunction

		function void apply_step();
			applied = step_idx;
			drive_on = 1'b1;
			ph = PH_AWAIT;
			ticks = 0;
		endfunction

		function void enter_dwell();
			step_idx = after_step(step_idx);
			ticks = 0;
			ph = PH_DWELL;
			if (dwell_len == 0)
				apply_step();
		endfunction

		function void note_hall_item(logic [2:0] halls);
			drive_item_t want;
			int unsigned span;
			if (ph == PH_STARTUP) begin
				if (boot_steps >= 6 * boot_cycles) begin
					apply_step();
				end else begin
					span = (boot_len == 0) ? 1 : boot_len;
					if (ticks == 0) begin
						applied = step_idx;
						drive_on = boot_drive;
					end
					ticks++;
					if (ticks >= span) begin
						ticks = 0;
						step_idx = after_step(step_idx);
						boot_steps = boot_steps + 1'b1;
						if (boot_steps >= 6 * boot_cycles)
							apply_step();
					end
				end
			end else if (ph == PH_SETTLE) begin
				ticks++;
				if (ticks >= settle_len)
					enter_dwell();
			end else if (ph == PH_DWELL) begin
				ticks++;
				if (ticks >= dwell_len)
					apply_step();
			end
			// The hall comparison also runs on the tick that leaves startup, settle or dwell.
			if (ph == PH_AWAIT && halls == hall_code(after_step(step_idx))) begin
				ticks = 0;
				ph = PH_SETTLE;
				if (settle_len == 0)
					enter_dwell();
			end
			want.a = DRV_FLOAT;
			want.b = DRV_FLOAT;
			want.c = DRV_FLOAT;
			if (drive_on) begin
				case (applied)
					3'd0: begin
						want.a = DRV_HIGH;
						want.b = DRV_LOW;
					end
					3'd1: begin
						want.b = DRV_LOW;
						want.c = DRV_HIGH;
					end
					3'd2: begin
						want.a = DRV_LOW;
						want.c = DRV_HIGH;
					end
					3'd3: begin
						want.a = DRV_LOW;
						want.b = DRV_HIGH;
					end
					3'd4: begin
						want.b = DRV_HIGH;
						want.c = DRV_LOW;
					end
					default: begin
						want.a = DRV_HIGH;
						want.c = DRV_LOW;
					end
				endcase
			end
			want.step = step_idx;
			want.phase = ph;
			pending_drives.push_back(want);
		endfunction

		function void check_drive_item(drive_item_t seen);
			drive_item_t want;
			if (pending_drives.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected drive item: a=%0d b=%0d c=%0d step=%0d phase=%0d",
						seen.a, seen.b, seen.c, seen.step, seen.phase);
				return;
			end
			want = pending_drives.pop_front();
			if (seen.a !== want.a || seen.b !== want.b || seen.c !== want.c
					|| seen.step !== want.step || seen.phase !== want.phase) begin
				failures++;
				if (failures <= 10)
					$display({"drive item mismatch: expected a=%0d b=%0d c=%0d step=%0d phase=%0d,",
						" got a=%0d b=%0d c=%0d step=%0d phase=%0d"},
						want.a, want.b, want.c, want.step, want.phase,
						seen.a, seen.b, seen.c, seen.step, seen.phase);
			end
		endfunction
	endclass

endpackage

FILE: tb/tb_top.sv
// Top level testbench of the hall sensor six-step commutator.
`timescale 1ns / 100ps
module tb_top;
	import hssc_pkg::*;
	import hssc_tb_pkg::*;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	cfg_index_t cfg_index;
	logic [CfgDataW-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic hall_a;
	logic hall_b;
	logic hall_c;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [DriveW-1:0] drive_a;
	logic [DriveW-1:0] drive_b;
	logic [DriveW-1:0] drive_c;
	logic [StepW-1:0] current_step;
	logic [1:0] current_phase;

	commutation_scoreboard sb;
	drive_item_t seen_drive;
	bit quiet;
	int rx_hold = 0;
	int unsigned items_sent;

	hall_sensor_six_step_commutator uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.hall_a(hall_a),
		.hall_b(hall_b),
		.hall_c(hall_c),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.drive_a(drive_a),
		.drive_b(drive_b),
		.drive_c(drive_c),
		.current_step(current_step),
		.current_phase(current_phase)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int pick_pause();
		if ($urandom_range(0, 9) != 0)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [CfgDataW-1:0] pick_len();
		int r;
		r = $urandom_range(0, 9);
		if (r < 2)
			return '0;
		if (r < 8)
			return CfgDataW'($urandom_range(1, 6));
		if (r < 9)
			return CfgDataW'($urandom_range(7, 40));
		return CfgDataW'($urandom_range(41, 300));
	endfunction

	// Mostly the pattern of the next step, so that the closed loop keeps turning.
	function automatic logic [2:0] pick_halls();
		int r;
		r = $urandom_range(0, 99);
		if (sb.ph == PH_STARTUP || r < 20)
			return 3'($urandom);
		if (r < 35)
			return hall_code(sb.step_idx);
		return hall_code(after_step(sb.step_idx));
	endfunction

	task automatic send_halls(input logic [2:0] halls);
		int gap;
		gap = (quiet || $urandom_range(0, 99) < 65) ? 0 : pick_pause();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		{hall_a, hall_b, hall_c} <= halls;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_hall_item(halls);
		items_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending_drives.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic put_reg(input cfg_index_t idx, input logic [CfgDataW-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		sb.write_reg(idx, value);
	endtask

	task automatic load_regs(input logic [CfgDataW-1:0] step_len, input logic [CfgDataW-1:0] cycles,
			input logic [CfgDataW-1:0] settle, input logic [CfgDataW-1:0] dwell,
			input logic [CfgDataW-1:0] boot_drv);
		put_reg(CFG_STARTUP_STEP_US, step_len);
		put_reg(CFG_STARTUP_CYCLES, cycles);
		put_reg(CFG_SETTLE_US, settle);
		put_reg(CFG_DWELL_US, dwell);
		put_reg(CFG_STARTUP_DRIVE, boot_drv);
		cfg_we <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (rx_hold != 0) begin
			rx_hold--;
			out_ready <= 1'b0;
		end else if (quiet || $urandom_range(0, 99) < 70) begin
			out_ready <= 1'b1;
		end else begin
			rx_hold = pick_pause();
			out_ready <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			seen_drive.a = drive_t'(drive_a);
			seen_drive.b = drive_t'(drive_b);
			seen_drive.c = drive_t'(drive_c);
			seen_drive.step = current_step;
			seen_drive.phase = phase_t'(current_phase);
			sb.check_drive_item(seen_drive);
		end
	end

	initial begin
		int span;
		int round;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_STARTUP_STEP_US;
		cfg_data <= '0;
		in_valid <= 1'b0;
		hall_a <= 1'b0;
		hall_b <= 1'b0;
		hall_c <= 1'b0;
		quiet = 1'b0;
		items_sent = 0;
		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Default registers: startup with floating coils, every hall combination.
		for (int i = 0; i < 8; i++)
			send_halls(3'(i));
		drain();
		// A zero startup step length counts as one tick.
		load_regs('0, CfgDataW'(1), '0, '0, '0);
		repeat (3) send_halls(3'b111);
		drain();
		// Driven startup runs into the closed loop, where zero settle and dwell pass at once.
		put_reg(CFG_STARTUP_DRIVE, CfgDataW'(1));
		cfg_we <= 1'b0;
		for (int i = 0; i < 14; i++)
			send_halls((i == 9) ? 3'b000 : hall_code(after_step(sb.step_idx)));

		round = 0;
		while (items_sent < 1300) begin
			drain();
			if (round == 2)
				load_regs('1, CfgDataW'(255), '1, '1, CfgDataW'(1));
			else if (round == 3)
				load_regs(CfgDataW'(1), '0, '0, CfgDataW'(1), '0);
			else
				load_regs(CfgDataW'($urandom), CfgDataW'($urandom_range(0, 255)), pick_len(),
					pick_len(), CfgDataW'($urandom_range(0, 1)));
			quiet = ($urandom_range(0, 3) == 0);
			span = (round == 2) ? 60 : $urandom_range(120, 240);
			repeat (span)
				send_halls(pick_halls());
			round++;
		end
		quiet = 1'b0;
		drain();
		repeat (10) @(posedge clk);
		if (sb.failures == 0 && sb.pending_drives.size() == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

	initial begin
		#12_000_000;
		$display("tb_top failed");
		$finish;
	end

endmodule
